/* sv/bounded_integer_set_core_macros.svh */
// Assertion macros used by the checker file of the bounded integer set.
`ifndef BOUNDED_INTEGER_SET_CORE_MACROS_SVH
`define BOUNDED_INTEGER_SET_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BIS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bis_pkg.sv */
// Types and constants of the bounded integer set.
package bis_pkg;

    localparam int MODE_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MEMBER     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOT_MEMBER = 3'd6;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_RESULT
    } fsm_state_t;

endpackage

/* sv/bis_ram.sv */
// Entry store: one write port, one read port with registered read data.
module bis_ram
    import bis_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [VALUE_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [VALUE_W-1:0] rd_data
);

    logic [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/bounded_integer_set_core.sv */
// Top level of the bounded integer set: scan/shift sequencer around the entry store.
//
//  channel | dir | group                      | fields (lsb first)
//  --------+-----+----------------------------+-----------------------------------
//  s       | in  | s_tvalid s_tready s_tdata  | mode[1:0] value[33:2] (pad to 40)
//  m       | out | m_tvalid m_tready m_tdata  | status[2:0] entry_count[7:3]
//
// After an item is accepted, the entries are read one a cycle from the single read port of
// the store, in order, until the first match (add, query) or the end (remove, which writes
// each later entry one place down as it passes); then the last entry read is checked, the
// scan closes and the result is loaded.
// The result sits in an output register, so a new item is taken while it waits; the one
// after that is held in the sequencer and keeps the input off until the register frees.
// Reset clears the count and control only; the store needs no clearing pass.
module bounded_integer_set_core
    import bis_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // mode[1:0], value[33:2], zeros above
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // status[2:0], entry_count[7:3]
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = CW + COUNT_W;

    fsm_state_t state_reg, state_next;

    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [CW-1:0]       chk_idx_reg, chk_idx_next;
    logic                found_reg, found_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    logic               in_take;
    logic               is_add;
    logic               is_remove;
    logic               match;
    logic               hit;
    logic               found_now;
    logic               more_to_read;
    logic               scan_end;
    logic               out_free;
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [VALUE_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [VALUE_W-1:0] ram_rd_data;
    logic [CW-1:0]      prev_idx;
    logic [EW-1:0]      cnt_ext;

    bis_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    assign s_tready     = (state_reg == FSM_IDLE);
    assign in_take      = s_tvalid && s_tready;
    assign is_add       = (mode_reg == MODE_ADD);
    assign is_remove    = (mode_reg == MODE_REMOVE);
    assign match        = (ram_rd_data == value_reg);
    assign hit          = chk_vld_reg && match && !found_reg;
    assign found_now    = found_reg || hit;
    assign more_to_read = (rd_ptr_reg < cnt_reg);
    // add and query stop at the first match; remove runs on to shift the tail
    assign scan_end     = (hit && !is_remove) || (!chk_vld_reg && !more_to_read);
    assign out_free     = !out_valid_reg || m_tready;
    assign prev_idx     = chk_idx_reg - CW'(1);
    assign cnt_ext      = EW'(cnt_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (in_take)
                begin
                    state_next = FSM_SCAN;
                end
            end
            FSM_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = FSM_RESULT;
                end
            end
            FSM_RESULT:
            begin
                if (out_free)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb
    begin
        cnt_next        = cnt_reg;
        rd_ptr_next     = rd_ptr_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        found_next      = found_reg;
        mode_next       = mode_reg;
        value_next      = value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        ram_rd_en       = 1'b0;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = prev_idx[AW-1:0];
        ram_wr_data     = ram_rd_data;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (in_take)
                begin
                    mode_next   = s_tdata[MODE_W-1:0];
                    value_next  = s_tdata[MODE_W+VALUE_W-1:MODE_W];
                    rd_ptr_next = '0;
                    found_next  = 1'b0;
                end
            end
            FSM_SCAN:
            begin
                found_next = found_now;
                if (more_to_read && !scan_end)
                begin
                    ram_rd_en    = 1'b1;
                    rd_ptr_next  = rd_ptr_reg + CW'(1);
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_ptr_reg;
                end
                // entries past the removed one move down a place
                if (chk_vld_reg && found_reg && is_remove)
                begin
                    ram_wr_en = 1'b1;
                end
                if (scan_end)
                begin
                    if (is_add)
                    begin
                        if (found_now)
                        begin
                            res_status_next = ST_DUPLICATE;
                        end
                        else if (cnt_reg >= CW'(CAPACITY))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            res_status_next = ST_ADDED;
                            ram_wr_en       = 1'b1;
                            ram_wr_addr     = cnt_reg[AW-1:0];
                            ram_wr_data     = value_reg;
                            cnt_next        = cnt_reg + CW'(1);
                        end
                    end
                    else if (is_remove)
                    begin
                        if (found_now)
                        begin
                            res_status_next = ST_REMOVED;
                            cnt_next        = cnt_reg - CW'(1);
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    else
                    begin
                        res_status_next = found_now ? ST_MEMBER : ST_NOT_MEMBER;
                    end
                end
            end
            FSM_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_count_next  = cnt_ext[COUNT_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            cnt_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg     <= rd_ptr_next;
        chk_idx_reg    <= chk_idx_next;
        found_reg      <= found_next;
        mode_reg       <= mode_next;
        value_reg      <= value_next;
        res_status_reg <= res_status_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_status_reg};

endmodule

/* sv/bis_checker.sv */
// Port-level checks of the bounded integer set, bound to the top level.
`include "bounded_integer_set_core_macros.svh"

module bis_checker
    import bis_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    localparam int EW = COUNT_W + 11;
    localparam logic [EW-1:0] CAP_EXT = EW'(CAPACITY);

    logic [STATUS_W-1:0] st;
    logic [COUNT_W-1:0]  cnt;
    logic                in_take;

    assign st      = m_tdata[STATUS_W-1:0];
    assign cnt     = m_tdata[STATUS_W+COUNT_W-1:STATUS_W];
    assign in_take = s_tvalid && s_tready && (s_tdata != {S_DATA_W{1'b0}} || 1'b1);

    `BIS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result changed while stalled")

    `BIS_ASSERT_NOW(a_full_count, clk, rst_n, m_tvalid && st == ST_FULL,
        cnt == CAP_EXT[COUNT_W-1:0], "full reported below capacity")

    `BIS_ASSERT_NOW(a_status_code, clk, rst_n, m_tvalid,
        st != 3'd7, "undefined status code")

    `BIS_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_take,
        !s_tready, "item taken while previous one still in progress")

endmodule

bind bounded_integer_set_core bis_checker #(.CAPACITY(CAPACITY)) u_bis_checker (.*);
